// ----- sv/slip_crc_frame_decoder_macros.svh -----
// Assertion macros for the SLIP CRC frame decoder.
// Used by the modules that carry concurrent assertions; no other dependencies.
`ifndef SLIP_CRC_FRAME_DECODER_MACROS_SVH
`define SLIP_CRC_FRAME_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define SCF_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define SCF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SCF_ASSERT(name, clk, rst_n, prop)
`define SCF_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/scf_pkg.sv -----
// Shared constants, types and widths of the SLIP CRC frame decoder.
// No dependencies; the modules import this package and scf_if names it by scope.
`timescale 1ns / 1ps

package scf_pkg;

	localparam int LENGTH_BITS   = 17;
	localparam int BYTE_W        = 8;
	localparam int MAX_PAYLOAD_W = 16;
	localparam int PKT_LEN_W     = 17;
	localparam int CRC_W         = 32;
	localparam int CMP_W         = (LENGTH_BITS > PKT_LEN_W) ? LENGTH_BITS : PKT_LEN_W;

	localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << LENGTH_BITS) - 64'd1);
	localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 16'd1024;

	localparam logic [BYTE_W-1:0] SLIP_END     = 8'hC0;
	localparam logic [BYTE_W-1:0] SLIP_ESC     = 8'hDB;
	localparam logic [BYTE_W-1:0] SLIP_ESC_END = 8'hDC;
	localparam logic [BYTE_W-1:0] SLIP_ESC_ESC = 8'hDD;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

	typedef logic [LENGTH_BITS-1:0] count_t;

	typedef struct packed {
		logic                 is_status;
		logic [BYTE_W-1:0]    data_byte;
		logic [PKT_LEN_W-1:0] packet_length;
		logic                 crc_error;
		logic                 short_error;
		logic                 dangling_escape;
		logic                 bad_escape;
		logic                 too_big;
	} result_t;

endpackage

// ----- sv/scf_if.sv -----
// Valid/ready channel interfaces for received bytes and decoder results.
// Depends on scf_pkg for the field widths.
`timescale 1ns / 1ps

interface scf_byte_if;
	logic                         valid;
	logic                         ready;
	logic [scf_pkg::BYTE_W-1:0]   rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface scf_result_if;
	logic                           valid;
	logic                           ready;
	logic                           is_status;
	logic [scf_pkg::BYTE_W-1:0]     data_byte;
	logic [scf_pkg::PKT_LEN_W-1:0]  packet_length;
	logic                           crc_error;
	logic                           short_error;
	logic                           dangling_escape;
	logic                           bad_escape;
	logic                           too_big;

	modport source (
		output valid, output is_status, output data_byte, output packet_length,
		output crc_error, output short_error, output dangling_escape,
		output bad_escape, output too_big, input ready
	);
	modport sink (
		input valid, input is_status, input data_byte, input packet_length,
		input crc_error, input short_error, input dangling_escape,
		input bad_escape, input too_big, output ready
	);
endinterface

// ----- sv/scf_crc_step.sv -----
// Byte-wide update of a reflected CRC-32, eight bit steps unrolled.
// Depends on scf_pkg for the polynomial and widths.
`timescale 1ns / 1ps

module scf_crc_step (
	input  logic [scf_pkg::CRC_W-1:0]  crc,
	input  logic [scf_pkg::BYTE_W-1:0] data,
	output logic [scf_pkg::CRC_W-1:0]  crc_next
);
	import scf_pkg::*;

	logic [CRC_W-1:0] acc;

	always_comb begin
		acc = crc ^ CRC_W'(data);
		for (int k = 0; k < BYTE_W; k++) begin
			acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
		end
		crc_next = acc;
	end
endmodule

// ----- sv/scf_frame_core.sv -----
// Frame state of the decoder: escape handling, trailer hold, running CRC and status.
// Depends on scf_pkg, scf_crc_step and the assertion macro header.
`timescale 1ns / 1ps
`include "slip_crc_frame_decoder_macros.svh"

module scf_frame_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [scf_pkg::MAX_PAYLOAD_W-1:0]   cfg_write_data,
	input  logic                                fire,
	input  logic [scf_pkg::BYTE_W-1:0]          byte_s1,
	output logic                                res_valid,
	output scf_pkg::result_t                    res
);
	import scf_pkg::*;

	logic [MAX_PAYLOAD_W-1:0] max_q;
	logic                     esc_q, esc_n;
	logic                     first_q, first_n;
	count_t                   count_q, count_n;
	logic                     bad_q, bad_n;
	logic                     big_q, big_n;
	logic [CRC_W-1:0]         crc_q, crc_n, crc_next;
	logic [BYTE_W-1:0]        hold_q [4];

	logic                     is_end;
	logic [BYTE_W-1:0]        val;
	logic [CMP_W-1:0]         cap_raw, cap, count_ext;
	logic                     store_en, shift_en;
	logic                     short_err, crc_err, any_err;
	logic [CRC_W-1:0]         trailer;
	count_t                   len_full;

	scf_crc_step u_crc (
		.crc      (crc_q),
		.data     (hold_q[0]),
		.crc_next (crc_next)
	);

	assign is_end    = (byte_s1 == SLIP_END);
	assign cap_raw   = CMP_W'({1'b0, max_q}) + CMP_W'(4);
	assign cap       = (cap_raw > COUNT_MAX) ? COUNT_MAX : cap_raw;
	assign count_ext = CMP_W'(count_q);
	assign trailer   = {hold_q[3], hold_q[2], hold_q[1], hold_q[0]};
	assign short_err = (count_q < LENGTH_BITS'(4));
	assign crc_err   = !short_err && ((crc_q ^ CRC_INIT) != trailer);
	assign any_err   = esc_q || short_err || crc_err || bad_q || big_q;
	assign len_full  = any_err ? count_q : (count_q - LENGTH_BITS'(4));

	always_comb begin
		esc_n     = esc_q;
		first_n   = first_q;
		count_n   = count_q;
		bad_n     = bad_q;
		big_n     = big_q;
		crc_n     = crc_q;
		store_en  = 1'b0;
		shift_en  = 1'b0;
		val       = byte_s1;
		res_valid = 1'b0;
		res       = '0;
		if (is_end) begin
			res_valid           = 1'b1;
			res.is_status       = 1'b1;
			res.packet_length   = PKT_LEN_W'(len_full);
			res.crc_error       = crc_err;
			res.short_error     = short_err;
			res.dangling_escape = esc_q;
			res.bad_escape      = bad_q;
			res.too_big         = big_q;
			first_n             = 1'b0;
			esc_n               = 1'b0;
			count_n             = '0;
			bad_n               = 1'b0;
			big_n               = 1'b0;
			crc_n               = CRC_INIT;
		end else if (!esc_q && (byte_s1 == SLIP_ESC)) begin
			esc_n = 1'b1;
		end else begin
			if (esc_q) begin
				case (byte_s1)
					SLIP_ESC_END: val = SLIP_END;
					SLIP_ESC_ESC: val = SLIP_ESC;
					default:      bad_n = 1'b1;
				endcase
			end
			esc_n = 1'b0;
			if (count_ext >= cap) begin
				big_n = 1'b1;
			end else if ((count_q == '0) && (val == '0) && first_q) begin
				count_n = count_q;
			end else if (short_err) begin
				store_en = 1'b1;
				count_n  = count_q + LENGTH_BITS'(1);
			end else begin
				shift_en      = 1'b1;
				crc_n         = crc_next;
				count_n       = count_q + LENGTH_BITS'(1);
				res_valid     = 1'b1;
				res.data_byte = hold_q[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= MAX_PAYLOAD_RESET;
			esc_q   <= 1'b0;
			first_q <= 1'b1;
			count_q <= '0;
			bad_q   <= 1'b0;
			big_q   <= 1'b0;
			crc_q   <= CRC_INIT;
		end else begin
			if (cfg_write_en) begin
				max_q <= cfg_write_data;
			end
			if (fire) begin
				esc_q   <= esc_n;
				first_q <= first_n;
				count_q <= count_n;
				bad_q   <= bad_n;
				big_q   <= big_n;
				crc_q   <= crc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && store_en) begin
			hold_q[count_q[1:0]] <= val;
		end else if (fire && shift_en) begin
			hold_q[0] <= hold_q[1];
			hold_q[1] <= hold_q[2];
			hold_q[2] <= hold_q[3];
			hold_q[3] <= val;
		end
	end

	`SCF_ASSERT_NEXT(a_end_clears_frame, clk, arst_n, fire && is_end, (count_q == '0) && !esc_q && (crc_q == CRC_INIT))
	`SCF_ASSERT(a_data_needs_trailer, clk, arst_n, (res_valid && !res.is_status) |-> (count_q >= LENGTH_BITS'(4)))
	`SCF_ASSERT(a_first_falls_on_end, clk, arst_n, $fell(first_q) |-> $past(fire && is_end))
endmodule

// ----- sv/scf_out_reg.sv -----
// Result register that drives the output channel and frees itself when taken.
// Depends on scf_pkg and the scf_result_if interface.
`timescale 1ns / 1ps

module scf_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              res_valid,
	input  scf_pkg::result_t  res,
	output logic              free,
	scf_result_if.source      result
);
	import scf_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load && res_valid) begin
			data_q <= res;
		end
	end

	assign result.valid           = valid_q;
	assign result.is_status       = data_q.is_status;
	assign result.data_byte       = data_q.data_byte;
	assign result.packet_length   = data_q.packet_length;
	assign result.crc_error       = data_q.crc_error;
	assign result.short_error     = data_q.short_error;
	assign result.dangling_escape = data_q.dangling_escape;
	assign result.bad_escape      = data_q.bad_escape;
	assign result.too_big         = data_q.too_big;
endmodule

// ----- sv/slip_crc_frame_decoder.sv -----
// SLIP frame decoder with CRC-32 trailer check; one received byte per cycle while the result channel does not stall.
// An accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle unless stalled; the frame state loop through the CRC byte step has one register.
// Reset (arst_n low) clears the frame state, sets the running CRC to all ones and max_payload to 1024.
// Depends on scf_pkg, scf_if, scf_frame_core and scf_out_reg.
`timescale 1ns / 1ps

module slip_crc_frame_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [scf_pkg::MAX_PAYLOAD_W-1:0]  cfg_write_data,
	scf_byte_if.sink                           rx,
	scf_result_if.source                       result
);
	import scf_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              free;
	logic              fire;
	logic              res_valid;
	result_t           res;

	assign rx.ready = !valid_s1 || free;
	assign fire     = valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	scf_frame_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.fire           (fire),
		.byte_s1        (byte_s1),
		.res_valid      (res_valid),
		.res            (res)
	);

	scf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res_valid (res_valid),
		.res       (res),
		.free      (free),
		.result    (result)
	);
endmodule
